>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define MCWT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// cond must never be true outside reset
`define MCWT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

>>> src/mcwt_pkg.sv
// ----------------------------------------------------------------------------
// mcwt_pkg
// Types and constants shared by the watchdog table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcwt_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int ID_W   = 5;
   localparam int TIME_W = 32;
   localparam int REQ_W  = 2;

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = REQ_W;
   localparam int RSP_TDATA_W = 48;

   localparam logic [REQ_W-1:0] REQ_REGISTER  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_HEARTBEAT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CHECK     = 2'd2;

   // strobes from the sequencer to the channel memory
   typedef struct packed {
      logic wr_alive;
      logic wr_limit;
      logic rd_en;
   } mcwt_mem_cmd_type;

   typedef struct packed {
      logic              accepted;
      logic [ID_W-1:0]   assigned_id;
      logic              timed_out;
      logic [ID_W-1:0]   failing_id;
      logic [TIME_W-1:0] elapsed_ms;
      logic              kick;
   } mcwt_rsp_type;

endpackage

`default_nettype wire

>>> src/mcwt_table.sv
// ----------------------------------------------------------------------------
// mcwt_table
// Channel memory: last-alive stamp and delay limit per channel, one write
// port and one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module mcwt_table #(
   parameter int SLOTS = mcwt_pkg::SLOTS_DEFAULT,
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                          clock,
   input  wire mcwt_pkg::mcwt_mem_cmd_type    mem_cmd,
   input  wire logic [IDX_W-1:0]              wr_addr,
   input  wire logic [mcwt_pkg::TIME_W-1:0]   alive_wdata,
   input  wire logic [mcwt_pkg::TIME_W-1:0]   limit_wdata,
   input  wire logic [IDX_W-1:0]              rd_addr,
   output logic      [mcwt_pkg::TIME_W-1:0]   alive_rdata,
   output logic      [mcwt_pkg::TIME_W-1:0]   limit_rdata
);
   import mcwt_pkg::*;

   logic [TIME_W-1:0] alive_mem [SLOTS];
   logic [TIME_W-1:0] limit_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_alive) begin
         alive_mem[wr_addr] <= alive_wdata;
      end
      if (mem_cmd.rd_en) begin
         alive_rdata <= alive_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_limit) begin
         limit_mem[wr_addr] <= limit_wdata;
      end
      if (mem_cmd.rd_en) begin
         limit_rdata <= limit_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/mcwt_ctrl.sv
// ----------------------------------------------------------------------------
// mcwt_ctrl
// Request sequencer: registers channels, applies heartbeats and scans the
// table one entry per cycle on a check.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mcwt_ctrl #(
   parameter int SLOTS = mcwt_pkg::SLOTS_DEFAULT,
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int CNT_W = $clog2(SLOTS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mcwt_pkg::REQ_W-1:0]    req_type,
   input  wire logic [mcwt_pkg::ID_W-1:0]     channel_id,
   input  wire logic [mcwt_pkg::TIME_W-1:0]   delay_limit,
   input  wire logic [mcwt_pkg::TIME_W-1:0]   now_ms,
   // result
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output mcwt_pkg::mcwt_rsp_type             res,
   // channel memory
   output mcwt_pkg::mcwt_mem_cmd_type         mem_cmd,
   output logic      [IDX_W-1:0]              wr_addr,
   output logic      [mcwt_pkg::TIME_W-1:0]   alive_wdata,
   output logic      [mcwt_pkg::TIME_W-1:0]   limit_wdata,
   output logic      [IDX_W-1:0]              rd_addr,
   input  wire logic [mcwt_pkg::TIME_W-1:0]   alive_rdata,
   input  wire logic [mcwt_pkg::TIME_W-1:0]   limit_rdata
);
   import mcwt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  used_cnt_ff, used_cnt_in;
   logic [IDX_W-1:0]  eval_idx_ff, eval_idx_in;
   logic [TIME_W-1:0] now_ff, now_in;
   mcwt_rsp_type      res_ff, res_in;

   logic                  req_fire;
   logic                  table_full;
   logic [CNT_W-1:0]      next_id;
   logic [CNT_W+ID_W-1:0] next_id_ext;
   logic                  hb_in_range;
   logic [IDX_W+ID_W-1:0] hb_idx_ext;
   logic [IDX_W:0]        eval_next;
   logic [IDX_W+ID_W:0]   eval_next_ext;
   logic                  eval_last;
   logic [TIME_W-1:0]     elapsed;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   assign table_full  = (used_cnt_ff >= CNT_W'(SLOTS));
   assign next_id     = used_cnt_ff + CNT_W'(1);
   assign next_id_ext = {{ID_W{1'b0}}, next_id};

   assign hb_in_range = (channel_id != '0) &&
                        ({{CNT_W{1'b0}}, channel_id} <= (CNT_W+ID_W)'(SLOTS));
   assign hb_idx_ext  = {{IDX_W{1'b0}}, channel_id - ID_W'(1)};

   // entry under evaluation is 0-based, ids are 1-based
   assign eval_next     = {1'b0, eval_idx_ff} + (IDX_W+1)'(1);
   assign eval_next_ext = {{ID_W{1'b0}}, eval_next};
   assign eval_last     = (eval_next == (IDX_W+1)'(used_cnt_ff));
   assign elapsed       = now_ff - alive_rdata;

   assign alive_wdata = now_ms;
   assign limit_wdata = delay_limit;

   always_comb begin
      state_in    = state_ff;
      used_cnt_in = used_cnt_ff;
      eval_idx_in = eval_idx_ff;
      now_in      = now_ff;
      res_in      = res_ff;
      mem_cmd     = '0;
      wr_addr     = used_cnt_ff[IDX_W-1:0];
      rd_addr     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = now_ms;
               res_in   = '0;
               state_in = ST_DONE;
               unique case (req_type)
                  REQ_REGISTER: begin
                     if (!table_full) begin
                        mem_cmd.wr_alive   = 1'b1;
                        mem_cmd.wr_limit   = 1'b1;
                        used_cnt_in        = next_id;
                        res_in.accepted    = 1'b1;
                        res_in.assigned_id = next_id_ext[ID_W-1:0];
                     end
                  end
                  REQ_HEARTBEAT: begin
                     res_in.kick = 1'b1;
                     if (hb_in_range) begin
                        mem_cmd.wr_alive = 1'b1;
                        wr_addr          = hb_idx_ext[IDX_W-1:0];
                        res_in.accepted  = 1'b1;
                     end
                  end
                  REQ_CHECK: begin
                     if (used_cnt_ff != '0) begin
                        mem_cmd.rd_en = 1'b1;
                        eval_idx_in   = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (elapsed > limit_rdata) begin
               res_in.timed_out  = 1'b1;
               res_in.failing_id = eval_next_ext[ID_W-1:0];
               res_in.elapsed_ms = elapsed;
               state_in          = ST_DONE;
            end else if (eval_last) begin
               state_in = ST_DONE;
            end else begin
               mem_cmd.rd_en = 1'b1;
               rd_addr       = eval_next[IDX_W-1:0];
               eval_idx_in   = eval_next[IDX_W-1:0];
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         used_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         used_cnt_ff <= used_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= eval_idx_in;
      now_ff      <= now_in;
      res_ff      <= res_in;
   end

   `MCWT_ASSERT(a_wr_only_on_req, clock, reset, (mem_cmd.wr_alive || mem_cmd.wr_limit) |-> req_fire)
   `MCWT_ASSERT(a_scan_in_table, clock, reset, (state_ff == ST_SCAN) |-> ((IDX_W+1)'(eval_idx_ff) < (IDX_W+1)'(used_cnt_ff)))
   `MCWT_ASSERT(a_busy_after_req, clock, reset, req_fire |=> (state_ff != ST_IDLE))
   `MCWT_NEVER(a_cnt_in_range, clock, reset, used_cnt_ff > CNT_W'(SLOTS))

endmodule

`default_nettype wire

>>> src/multi_channel_watchdog_table_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_watchdog_table_unit
// Heartbeat watchdog table: channel registration, heartbeats and timeout scan.
// ----------------------------------------------------------------------------
// Flow: each result is built in the sequencer's result register and then
//   moved into the output register; a check first reads the entries (up to
//   the registered count), one per cycle through the memory port.
// Throughput: one request at a time; the next is taken the cycle after the
//   result moves to the output register, which frees the sequencer at once.
// Reset: synchronous; clears the channel count and control. The memories are
//   not cleared: entries past the registered count are never read.
`default_nettype none

module multi_channel_watchdog_table_unit #(
   parameter int SLOTS = mcwt_pkg::SLOTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // channel_id[4:0], delay_limit[36:5], now_ms[68:37], zero pad
   input  wire logic [mcwt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type[1:0]
   input  wire logic [mcwt_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // accepted[0], assigned_id[5:1], timed_out[6], failing_id[11:7],
   // elapsed_ms[43:12], kick[44], zero pad
   output logic      [mcwt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import mcwt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   mcwt_mem_cmd_type  mem_cmd;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [TIME_W-1:0] alive_wdata, limit_wdata, alive_rdata, limit_rdata;

   logic         res_valid, res_ready;
   mcwt_rsp_type res;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   mcwt_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_type    (req_tuser[REQ_W-1:0]),
      .channel_id  (req_tdata[4:0]),
      .delay_limit (req_tdata[36:5]),
      .now_ms      (req_tdata[68:37]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_cmd     (mem_cmd),
      .wr_addr     (wr_addr),
      .alive_wdata (alive_wdata),
      .limit_wdata (limit_wdata),
      .rd_addr     (rd_addr),
      .alive_rdata (alive_rdata),
      .limit_rdata (limit_rdata)
   );

   mcwt_table #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock       (clock),
      .mem_cmd     (mem_cmd),
      .wr_addr     (wr_addr),
      .alive_wdata (alive_wdata),
      .limit_wdata (limit_wdata),
      .rd_addr     (rd_addr),
      .alive_rdata (alive_rdata),
      .limit_rdata (limit_rdata)
   );

   // output register: takes a result whenever it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, res.kick, res.elapsed_ms, res.failing_id,
                         res.timed_out, res.assigned_id, res.accepted};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> bench/tb_multi_channel_watchdog_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_channel_watchdog_table_unit
// Self-checking bench for the watchdog table. A directed run covers the empty
// table, bad heartbeat ids, the unused request code, time wrap and the limit
// extremes. Random traffic follows: mostly heartbeats to live channels and
// checks, with a few registrations that fill the table and then get refused.
// Each accepted request is scored by a local table model; every response beat
// is checked field by field against the oldest predicted response.
// ----------------------------------------------------------------------------

module tb_multi_channel_watchdog_table_unit;
   import mcwt_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1800;

   typedef struct {
      logic [REQ_W-1:0]  kind;
      logic [ID_W-1:0]   chan;
      logic [TIME_W-1:0] limit;
      logic [TIME_W-1:0] now;
      bit                drain_first;   // hold until all responses are back
   } watchdog_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   multi_channel_watchdog_table_unit #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // channel table mirror
   bit                chan_live  [SLOTS];
   logic [TIME_W-1:0] chan_stamp [SLOTS];
   logic [TIME_W-1:0] chan_limit [SLOTS];
   int                next_chan = 1;

   watchdog_req_type request_q[$];
   mcwt_rsp_type     outcome_q[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               gen_registered = 0;
   bit               calm;
   mcwt_rsp_type     seen_rsp, want_rsp;

   // no idling on either side in this window
   assign calm = cycle_count >= 1500 && cycle_count < 2700;

   function automatic mcwt_rsp_type watchdog_outcome(watchdog_req_type rq);
      mcwt_rsp_type      res;
      logic [TIME_W-1:0] span;
      res = '0;
      case (rq.kind)
         REQ_REGISTER: begin
            if (next_chan <= SLOTS) begin
               chan_live[next_chan-1]  = 1'b1;
               chan_limit[next_chan-1] = rq.limit;
               chan_stamp[next_chan-1] = rq.now;
               res.accepted    = 1'b1;
               res.assigned_id = ID_W'(next_chan);
               next_chan++;
            end
         end
         REQ_HEARTBEAT: begin
            // in-range id refreshes the stamp even if never registered
            if (rq.chan >= 1 && rq.chan <= SLOTS) begin
               chan_stamp[rq.chan-1] = rq.now;
               res.accepted = 1'b1;
            end
            res.kick = 1'b1;
         end
         REQ_CHECK: begin
            for (int s = 0; s < SLOTS && !res.timed_out; s++) begin
               span = rq.now - chan_stamp[s];
               if (chan_live[s] && span > chan_limit[s]) begin
                  res.timed_out  = 1'b1;
                  res.failing_id = ID_W'(s + 1);
                  res.elapsed_ms = span;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic add_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] chan,
                              input logic [TIME_W-1:0] limit, input logic [TIME_W-1:0] now,
                              input bit drain_first = 1'b0);
      watchdog_req_type rq;
      rq.kind        = kind;
      rq.chan        = chan;
      rq.limit       = limit;
      rq.now         = now;
      rq.drain_first = drain_first;
      request_q.push_back(rq);
      if (kind == REQ_REGISTER && gen_registered < SLOTS) gen_registered++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(watchdog_outcome(request_q.pop_front()));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (request_q.size() != 0 &&
                !(request_q[0].drain_first && outcome_q.size() != 0) &&
                (calm || $urandom_range(0, 99) >= 15)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, request_q[0].now, request_q[0].limit,
                              request_q[0].chan};
               req_tuser  <= request_q[0].kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.accepted    = rsp_tdata[0];
            seen_rsp.assigned_id = rsp_tdata[5:1];
            seen_rsp.timed_out   = rsp_tdata[6];
            seen_rsp.failing_id  = rsp_tdata[11:7];
            seen_rsp.elapsed_ms  = rsp_tdata[43:12];
            seen_rsp.kick        = rsp_tdata[44];
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with nothing expected: tdata=%h",
                           $realtime, rsp_tdata);
            end else begin
               want_rsp = outcome_q.pop_front();
               if (seen_rsp.accepted !== want_rsp.accepted ||
                   seen_rsp.assigned_id !== want_rsp.assigned_id ||
                   seen_rsp.timed_out !== want_rsp.timed_out ||
                   seen_rsp.failing_id !== want_rsp.failing_id ||
                   seen_rsp.elapsed_ms !== want_rsp.elapsed_ms ||
                   seen_rsp.kick !== want_rsp.kick) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch acc/id/to/fid/elapsed/kick exp %b/%0d/%b/%0d/%h/%b",
                              $realtime, want_rsp.accepted, want_rsp.assigned_id,
                              want_rsp.timed_out, want_rsp.failing_id,
                              want_rsp.elapsed_ms, want_rsp.kick,
                              " got %b/%0d/%b/%0d/%h/%b",
                              seen_rsp.accepted, seen_rsp.assigned_id,
                              seen_rsp.timed_out, seen_rsp.failing_id,
                              seen_rsp.elapsed_ms, seen_rsp.kick);
               end
            end
         end
         rsp_tready <= calm || $urandom_range(0, 99) >= 15;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_multi_channel_watchdog_table_unit failed");
         $finish;
      end
   end

   initial begin
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] lim;
      logic [ID_W-1:0]   id;
      int                r;

      // directed: empty table, bad ids, unused code, wrap, limit extremes
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'h0);
      add_request(REQ_UNUSED,    5'd31, 32'hFFFFFFFF, 32'hFFFFFFFF);
      add_request(REQ_HEARTBEAT, 5'd0,  32'h0,        32'd10);
      add_request(REQ_HEARTBEAT, 5'd17, 32'h0,        32'd11);
      add_request(REQ_HEARTBEAT, 5'd31, 32'hFFFFFFFF, 32'd12);
      add_request(REQ_HEARTBEAT, 5'd16, 32'h0,        32'd123);
      add_request(REQ_HEARTBEAT, 5'd5,  32'h0,        32'd77);
      add_request(REQ_REGISTER,  5'd0,  32'h0,        32'hFFFFFFF0);
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'hFFFFFFF0);
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'h00000004);  // wraps
      add_request(REQ_HEARTBEAT, 5'd1,  32'h0,        32'd4);
      add_request(REQ_REGISTER,  5'd31, 32'hFFFFFFFF, 32'd0);
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'd4);
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'd5);
      add_request(REQ_HEARTBEAT, 5'd2,  32'h0,        32'd3);
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'd2);
      add_request(REQ_REGISTER,  5'd0,  32'd100,      32'd1000);
      add_request(REQ_HEARTBEAT, 5'd1,  32'h0,        32'd1101);
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'd1100);
      add_request(REQ_CHECK,     5'd0,  32'h0,        32'd1101);

      t = 32'd2000;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 2) t = $urandom;
         else t = t + $urandom_range(0, 150);
         r = $urandom_range(0, 999);
         case ($urandom_range(0, 3))
            0: lim = $urandom_range(0, 300);
            1: lim = $urandom_range(300, 3000);
            2: lim = $urandom;
            default: lim = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
         endcase
         id = $urandom_range(0, 31);
         if (r < 20) begin
            add_request(REQ_REGISTER, id, lim, t, n == 0 || n == 900);
         end else if (r < 560) begin
            if (gen_registered > 0 && $urandom_range(0, 9) != 0)
               id = $urandom_range(1, gen_registered);
            add_request(REQ_HEARTBEAT, id, lim, t, n == 0 || n == 900);
         end else if (r < 980) begin
            // now and then a stray timestamp
            add_request(REQ_CHECK, id, lim, ($urandom_range(0, 99) < 3) ? $urandom : t,
                        n == 0 || n == 900);
         end else begin
            add_request(REQ_UNUSED, id, lim, $urandom, n == 0 || n == 900);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_tvalid) @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_multi_channel_watchdog_table_unit passed");
      end else begin
         $display("tb_multi_channel_watchdog_table_unit failed");
      end
      $finish;
   end

endmodule

>>> multi_channel_watchdog_table_unit.f
+incdir+src
src/mcwt_pkg.sv
src/mcwt_table.sv
src/mcwt_ctrl.sv
src/multi_channel_watchdog_table_unit.sv
bench/tb_multi_channel_watchdog_table_unit.sv
